### rtl/mwpo_pkg.sv
// Shared types, register codes and arithmetic constants of the multi-wave phase oscillator.
`default_nettype none

package mwpo_pkg;

    localparam int DEFAULT_VOICES = 8;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 32;
    localparam int MUL_W          = 33;
    localparam int PROD_W         = 2 * MUL_W;
    localparam int BASE_W         = 37;
    localparam int DIV_STEPS      = BASE_W;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_RATIO_NUM    = 3'd0;
    localparam logic [2:0] REG_RATIO_DEN    = 3'd1;
    localparam logic [2:0] REG_REF_INC      = 3'd2;
    localparam logic [2:0] REG_PHASE_OFFSET = 3'd3;
    localparam logic [2:0] REG_WAVE_SELECT  = 3'd4;
    localparam logic [2:0] REG_PULSE_WIDTH  = 3'd5;
    localparam logic [2:0] REG_FM_DEPTH     = 3'd6;

    // Wave codes
    localparam logic [1:0] WAVE_SINE  = 2'd0;
    localparam logic [1:0] WAVE_SAW   = 2'd1;
    localparam logic [1:0] WAVE_PULSE = 2'd2;
    localparam logic [1:0] WAVE_SPLIT = 2'd3;

    // Request function codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_RESET = 1'b1;

    // Register reset values
    localparam logic [4:0]  RST_RATIO_NUM = 5'd1;
    localparam logic [4:0]  RST_RATIO_DEN = 5'd1;
    localparam logic [31:0] RST_REF_INC   = 32'd23410733;

    // 2^(x/4096) cubic in Q16
    localparam logic [16:0] EXP_C3 = 17'd5121;
    localparam logic [16:0] EXP_C2 = 17'd14823;
    localparam logic [16:0] EXP_C1 = 17'd45584;
    localparam logic [16:0] EXP_C0 = 17'd65536;

    // Quarter sine odd polynomial in Q15
    localparam logic [16:0] SIN_C3 = 17'd2320;
    localparam logic [16:0] SIN_C2 = 17'd21024;
    localparam logic [16:0] SIN_C1 = 17'd51472;

    localparam logic [31:0] F_ONE = 32'h1000_0000;

    typedef struct packed {
        logic [4:0]         ratio_num;
        logic [4:0]         ratio_den;
        logic [31:0]        ref_increment;
        logic signed [15:0] phase_offset;
        logic [1:0]         wave_select;
        logic signed [15:0] pulse_width;
        logic signed [15:0] fm_depth;
    } cfg_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_RST_L,
        ST_RST_R,
        ST_MUL_NUM,
        ST_DIV_LD,
        ST_DIV,
        ST_MUL_E1,
        ST_ADD_E1,
        ST_MUL_E2,
        ST_ADD_E2,
        ST_MUL_E3,
        ST_ADD_E3,
        ST_MUL_BL,
        ST_ADD_BL,
        ST_MUL_BH,
        ST_ADD_BH,
        ST_SHIFT,
        ST_MUL_F,
        ST_ADD_F,
        ST_MUL_L,
        ST_ADD_L,
        ST_MUL_H,
        ST_ADD_H,
        ST_PHASE,
        ST_PREP,
        ST_MUL_S1,
        ST_ADD_S1,
        ST_MUL_S2,
        ST_ADD_S2,
        ST_MUL_S3,
        ST_ADD_S3,
        ST_MUL_S4,
        ST_WAVE,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

### rtl/mwpo_if.sv
// Request and result channel interfaces of the multi-wave phase oscillator.
`default_nettype none

interface mwpo_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [2:0]         voice;
    logic               channel;
    logic signed [15:0] pitch_cv;
    logic signed [15:0] fm_cv;

    modport source (output valid, func, voice, channel, pitch_cv, fm_cv, input ready);
    modport sink   (input valid, func, voice, channel, pitch_cv, fm_cv, output ready);
endinterface

interface mwpo_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [2:0]         out_voice;
    logic               out_channel;

    modport source (output valid, sample, out_voice, out_channel, input ready);
    modport sink   (input valid, sample, out_voice, out_channel, output ready);
endinterface

`default_nettype wire

### rtl/mwpo_cfg.sv
// APB-style configuration register file of the oscillator.
`default_nettype none

module mwpo_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mwpo_pkg::PADDR_W-1:0]      paddr,
    input  logic [mwpo_pkg::PDATA_W-1:0]      pwdata,
    output logic [mwpo_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    output mwpo_pkg::cfg_t                    cfg
);

    mwpo_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ratio_num     <= mwpo_pkg::RST_RATIO_NUM;
            cfg_reg.ratio_den     <= mwpo_pkg::RST_RATIO_DEN;
            cfg_reg.ref_increment <= mwpo_pkg::RST_REF_INC;
            cfg_reg.phase_offset  <= '0;
            cfg_reg.wave_select   <= mwpo_pkg::WAVE_SINE;
            cfg_reg.pulse_width   <= '0;
            cfg_reg.fm_depth      <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                mwpo_pkg::REG_RATIO_NUM:    cfg_reg.ratio_num     <= pwdata[4:0];
                mwpo_pkg::REG_RATIO_DEN:    cfg_reg.ratio_den     <= pwdata[4:0];
                mwpo_pkg::REG_REF_INC:      cfg_reg.ref_increment <= pwdata;
                mwpo_pkg::REG_PHASE_OFFSET: cfg_reg.phase_offset  <= pwdata[15:0];
                mwpo_pkg::REG_WAVE_SELECT:  cfg_reg.wave_select   <= pwdata[1:0];
                mwpo_pkg::REG_PULSE_WIDTH:  cfg_reg.pulse_width   <= pwdata[15:0];
                mwpo_pkg::REG_FM_DEPTH:     cfg_reg.fm_depth      <= pwdata[15:0];
                default:                    ;
            endcase
        end
    end

    // Read back raw register bits
    always_comb
    begin
        unique case (idx)
            mwpo_pkg::REG_RATIO_NUM:    prdata = {27'd0, cfg_reg.ratio_num};
            mwpo_pkg::REG_RATIO_DEN:    prdata = {27'd0, cfg_reg.ratio_den};
            mwpo_pkg::REG_REF_INC:      prdata = cfg_reg.ref_increment;
            mwpo_pkg::REG_PHASE_OFFSET: prdata = {16'd0, cfg_reg.phase_offset};
            mwpo_pkg::REG_WAVE_SELECT:  prdata = {30'd0, cfg_reg.wave_select};
            mwpo_pkg::REG_PULSE_WIDTH:  prdata = {16'd0, cfg_reg.pulse_width};
            mwpo_pkg::REG_FM_DEPTH:     prdata = {16'd0, cfg_reg.fm_depth};
            default:                    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/mwpo_phase_mem.sv
// Phase store: one 32-bit phase per voice and channel, with per-entry valid bits.
`default_nettype none

module mwpo_phase_mem #(
    parameter int DEPTH = 2 * mwpo_pkg::DEFAULT_VOICES,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [31:0]      wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [31:0]      rd_data
);

    logic [31:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [31:0]      rd_reg;
    logic             rd_valid_reg;

    // Write and registered read of the array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    // Track written entries; an unwritten entry reads as zero phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_reg : 32'd0;

endmodule

`default_nettype wire

### rtl/mwpo_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module mwpo_mul (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [mwpo_pkg::MUL_W-1:0]   op_a,
    input  logic signed [mwpo_pkg::MUL_W-1:0]   op_b,
    output logic signed [mwpo_pkg::PROD_W-1:0]  prod
);

    logic signed [mwpo_pkg::PROD_W-1:0] prod_reg;

    // Capture one product per issue
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### rtl/multi_wave_phase_oscillator.sv
// Top level: sequencer and datapath of the multi-wave phase oscillator.
//
// A tick request runs through one shared 33x33 signed multiplier and a bit-serial
// divider under a small sequencer, and the block takes no new request meanwhile.
// A tick uses the 37-step ratio divider and nine multiplier passes (thirteen for the
// sine wave), each but the last sine pass followed by a load or add step, plus the
// octave shift, phase update, wave and output steps. An out-of-range voice is dropped.
// The finished sample waits in an output register, so a stalled result only holds the
// sequencer once a second result is ready behind it.
`default_nettype none

module multi_wave_phase_oscillator #(
    parameter int VOICES = mwpo_pkg::DEFAULT_VOICES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mwpo_pkg::PADDR_W-1:0]  paddr,
    input  logic [mwpo_pkg::PDATA_W-1:0]  pwdata,
    output logic [mwpo_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    mwpo_in_if.sink                       in_ch,
    mwpo_out_if.source                    out_ch
);

    localparam int DEPTH = 2 * VOICES;
    localparam int IDX_W = $clog2(DEPTH);

    mwpo_pkg::cfg_t   cfg;
    mwpo_pkg::state_t state_reg, state_next;

    // Request fields
    logic [2:0]         voice_reg;
    logic               chan_reg;
    logic signed [15:0] pitch_reg;
    logic signed [15:0] fm_reg;
    logic [IDX_W-1:0]   addr_reg;

    // Work registers
    logic [mwpo_pkg::BASE_W-1:0] quot_reg;
    logic [4:0]                  rem_reg;
    logic [5:0]                  cnt_reg;
    logic [16:0]                 t_reg;
    logic [16:0]                 m_reg;
    logic [53:0]                 acc_reg;
    logic [44:0]                 v_reg;
    logic [31:0]                 f_reg;
    logic [31:0]                 lo_reg;
    logic [31:0]                 inc_reg;
    logic [31:0]                 p_reg;
    logic [15:0]                 x_reg;
    logic [15:0]                 x2_reg;
    logic signed [15:0]          sample_reg;

    // Output register
    logic               out_valid_reg;
    logic signed [15:0] out_sample_reg;
    logic [2:0]         out_voice_reg;
    logic               out_chan_reg;

    logic                                in_fire;
    logic                                voice_ok;
    logic [6:0]                          in_addr7;
    logic [6:0]                          left_addr7;
    logic [6:0]                          right_addr7;
    logic                                out_load;
    logic                                mul_en;
    logic signed [mwpo_pkg::MUL_W-1:0]   op_a;
    logic signed [mwpo_pkg::MUL_W-1:0]   op_b;
    logic signed [mwpo_pkg::PROD_W-1:0]  prod;
    logic                                mem_wr_en;
    logic [IDX_W-1:0]                    mem_wr_addr;
    logic [31:0]                         mem_wr_data;
    logic [31:0]                         phase_rd;
    logic [31:0]                         p_sum;
    logic [4:0]                          den_eff;
    logic [5:0]                          rem_sh;
    logic [5:0]                          rem_sub;
    logic                                rem_ge;
    logic [4:0]                          rem_next;
    logic [4:0]                          sh_amt;
    logic [14:0]                         fr;
    logic [15:0]                         x_w;
    logic signed [16:0]                  wave_s;
    logic signed [15:0]                  wave_sat;
    logic signed [16:0]                  saw_s;
    logic signed [16:0]                  split_s;
    logic signed [16:0]                  pulse_h;
    logic [31:0]                         pulse_thr;
    logic signed [16:0]                  sine_y;

    mwpo_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mwpo_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    mwpo_phase_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (addr_reg),
        .rd_data (phase_rd)
    );

    // Request handshake and addressing
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign voice_ok    = {29'd0, in_ch.voice} < 32'(VOICES);
    assign in_addr7    = {3'd0, in_ch.voice, in_ch.channel};
    assign left_addr7  = {3'd0, voice_reg, 1'b0};
    assign right_addr7 = {3'd0, voice_reg, 1'b1};
    assign out_load    = (state_reg == mwpo_pkg::ST_OUT) && (!out_valid_reg || out_ch.ready);

    // Divider step: one quotient bit per cycle
    assign den_eff  = (cfg.ratio_den == 5'd0) ? 5'd1 : cfg.ratio_den;
    assign rem_sh   = {rem_reg, quot_reg[mwpo_pkg::BASE_W-1]};
    assign rem_sub  = rem_sh - {1'b0, den_eff};
    assign rem_ge   = rem_sh >= {1'b0, den_eff};
    assign rem_next = rem_ge ? rem_sub[4:0] : rem_sh[4:0];

    // Octave shift: 16 minus the integer part of pitch
    assign sh_amt = 5'd16 - {pitch_reg[15], pitch_reg[15:12]};

    // New phase and sine argument folded into one quadrant
    assign p_sum = phase_rd + inc_reg;
    assign fr    = p_reg[29:15];
    assign x_w   = p_reg[30] ? (16'd32768 - {1'b0, fr}) : {1'b0, fr};

    // Wave shapes
    assign saw_s     = $signed({2'b00, p_reg[31:17]}) - 17'sd16384;
    assign split_s   = $signed({2'b00, p_reg[30:16]}) - 17'sd16384;
    assign pulse_h   = {cfg.pulse_width[15], cfg.pulse_width[15], cfg.pulse_width[15:1]};
    assign pulse_thr = {~cfg.pulse_width[15], cfg.pulse_width[14:0], 16'd0};
    assign sine_y    = $signed({1'b0, prod[31:16]});

    always_comb
    begin
        case (cfg.wave_select)
            mwpo_pkg::WAVE_SAW:   wave_s = saw_s;
            mwpo_pkg::WAVE_PULSE: wave_s = (p_reg > pulse_thr) ? (-17'sd16384 - pulse_h)
                                                                : (17'sd16384 - pulse_h);
            mwpo_pkg::WAVE_SPLIT: wave_s = (p_reg > 32'h8000_0000) ? -split_s : split_s;
            default:              wave_s = p_reg[31] ? -sine_y : sine_y;
        endcase
    end

    // Saturate to 16 bits
    always_comb
    begin
        if (wave_s > 17'sd32767)
        begin
            wave_sat = 16'sh7FFF;
        end
        else if (wave_s < -17'sd32768)
        begin
            wave_sat = 16'sh8000;
        end
        else
        begin
            wave_sat = wave_s[15:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mwpo_pkg::ST_IDLE:
            begin
                if (in_fire && voice_ok)
                begin
                    state_next = (in_ch.func == mwpo_pkg::FUNC_RESET) ? mwpo_pkg::ST_RST_L
                                                                     : mwpo_pkg::ST_MUL_NUM;
                end
            end
            mwpo_pkg::ST_RST_L:   state_next = mwpo_pkg::ST_RST_R;
            mwpo_pkg::ST_RST_R:   state_next = mwpo_pkg::ST_IDLE;
            mwpo_pkg::ST_MUL_NUM: state_next = mwpo_pkg::ST_DIV_LD;
            mwpo_pkg::ST_DIV_LD:  state_next = mwpo_pkg::ST_DIV;
            mwpo_pkg::ST_DIV:
            begin
                if (cnt_reg == 6'd0)
                begin
                    state_next = mwpo_pkg::ST_MUL_E1;
                end
            end
            mwpo_pkg::ST_MUL_E1:  state_next = mwpo_pkg::ST_ADD_E1;
            mwpo_pkg::ST_ADD_E1:  state_next = mwpo_pkg::ST_MUL_E2;
            mwpo_pkg::ST_MUL_E2:  state_next = mwpo_pkg::ST_ADD_E2;
            mwpo_pkg::ST_ADD_E2:  state_next = mwpo_pkg::ST_MUL_E3;
            mwpo_pkg::ST_MUL_E3:  state_next = mwpo_pkg::ST_ADD_E3;
            mwpo_pkg::ST_ADD_E3:  state_next = mwpo_pkg::ST_MUL_BL;
            mwpo_pkg::ST_MUL_BL:  state_next = mwpo_pkg::ST_ADD_BL;
            mwpo_pkg::ST_ADD_BL:  state_next = mwpo_pkg::ST_MUL_BH;
            mwpo_pkg::ST_MUL_BH:  state_next = mwpo_pkg::ST_ADD_BH;
            mwpo_pkg::ST_ADD_BH:  state_next = mwpo_pkg::ST_SHIFT;
            mwpo_pkg::ST_SHIFT:   state_next = mwpo_pkg::ST_MUL_F;
            mwpo_pkg::ST_MUL_F:   state_next = mwpo_pkg::ST_ADD_F;
            mwpo_pkg::ST_ADD_F:   state_next = mwpo_pkg::ST_MUL_L;
            mwpo_pkg::ST_MUL_L:   state_next = mwpo_pkg::ST_ADD_L;
            mwpo_pkg::ST_ADD_L:   state_next = mwpo_pkg::ST_MUL_H;
            mwpo_pkg::ST_MUL_H:   state_next = mwpo_pkg::ST_ADD_H;
            mwpo_pkg::ST_ADD_H:   state_next = mwpo_pkg::ST_PHASE;
            mwpo_pkg::ST_PHASE:   state_next = mwpo_pkg::ST_PREP;
            mwpo_pkg::ST_PREP:
            begin
                state_next = (cfg.wave_select == mwpo_pkg::WAVE_SINE) ? mwpo_pkg::ST_MUL_S1
                                                                      : mwpo_pkg::ST_WAVE;
            end
            mwpo_pkg::ST_MUL_S1:  state_next = mwpo_pkg::ST_ADD_S1;
            mwpo_pkg::ST_ADD_S1:  state_next = mwpo_pkg::ST_MUL_S2;
            mwpo_pkg::ST_MUL_S2:  state_next = mwpo_pkg::ST_ADD_S2;
            mwpo_pkg::ST_ADD_S2:  state_next = mwpo_pkg::ST_MUL_S3;
            mwpo_pkg::ST_MUL_S3:  state_next = mwpo_pkg::ST_ADD_S3;
            mwpo_pkg::ST_ADD_S3:  state_next = mwpo_pkg::ST_MUL_S4;
            mwpo_pkg::ST_MUL_S4:  state_next = mwpo_pkg::ST_WAVE;
            mwpo_pkg::ST_WAVE:    state_next = mwpo_pkg::ST_OUT;
            mwpo_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = mwpo_pkg::ST_IDLE;
                end
            end
            default:              state_next = mwpo_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: ready, multiplier operands, phase store writes
    always_comb
    begin
        in_ch.ready = (state_reg == mwpo_pkg::ST_IDLE);
        mul_en      = 1'b1;
        op_a        = '0;
        op_b        = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = addr_reg;
        mem_wr_data = p_sum;
        unique case (state_reg)
            mwpo_pkg::ST_MUL_NUM:
            begin
                op_a = $signed({1'b0, cfg.ref_increment});
                op_b = $signed({28'd0, cfg.ratio_num});
            end
            mwpo_pkg::ST_MUL_E1:
            begin
                op_a = $signed({16'd0, mwpo_pkg::EXP_C3});
                op_b = $signed({21'd0, pitch_reg[11:0]});
            end
            mwpo_pkg::ST_MUL_E2, mwpo_pkg::ST_MUL_E3:
            begin
                op_a = $signed({16'd0, t_reg});
                op_b = $signed({21'd0, pitch_reg[11:0]});
            end
            mwpo_pkg::ST_MUL_BL:
            begin
                op_a = $signed({1'b0, quot_reg[31:0]});
                op_b = $signed({16'd0, m_reg});
            end
            mwpo_pkg::ST_MUL_BH:
            begin
                op_a = $signed({28'd0, quot_reg[mwpo_pkg::BASE_W-1:32]});
                op_b = $signed({16'd0, m_reg});
            end
            mwpo_pkg::ST_MUL_F:
            begin
                op_a = {{17{fm_reg[15]}}, fm_reg};
                op_b = {{17{cfg.fm_depth[15]}}, cfg.fm_depth};
            end
            mwpo_pkg::ST_MUL_L:
            begin
                op_a = $signed({5'd0, v_reg[27:0]});
                op_b = $signed({f_reg[31], f_reg});
            end
            mwpo_pkg::ST_MUL_H:
            begin
                op_a = $signed({16'd0, v_reg[44:28]});
                op_b = $signed({f_reg[31], f_reg});
            end
            mwpo_pkg::ST_MUL_S1:
            begin
                op_a = $signed({17'd0, x_reg});
                op_b = $signed({17'd0, x_reg});
            end
            mwpo_pkg::ST_MUL_S2:
            begin
                op_a = $signed({16'd0, mwpo_pkg::SIN_C3});
                op_b = $signed({17'd0, x2_reg});
            end
            mwpo_pkg::ST_MUL_S3:
            begin
                op_a = $signed({16'd0, t_reg});
                op_b = $signed({17'd0, x2_reg});
            end
            mwpo_pkg::ST_MUL_S4:
            begin
                op_a = $signed({16'd0, t_reg});
                op_b = $signed({17'd0, x_reg});
            end
            mwpo_pkg::ST_RST_L:
            begin
                mul_en      = 1'b0;
                mem_wr_en   = 1'b1;
                mem_wr_addr = left_addr7[IDX_W-1:0];
                mem_wr_data = {cfg.phase_offset[14:0], 17'd0};
            end
            mwpo_pkg::ST_RST_R:
            begin
                mul_en      = 1'b0;
                mem_wr_en   = 1'b1;
                mem_wr_addr = right_addr7[IDX_W-1:0];
                mem_wr_data = 32'd0;
            end
            mwpo_pkg::ST_PHASE:
            begin
                mul_en    = 1'b0;
                mem_wr_en = 1'b1;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mwpo_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == mwpo_pkg::ST_DIV_LD)
            begin
                cnt_reg <= 6'(mwpo_pkg::DIV_STEPS - 1);
            end
            else if (state_reg == mwpo_pkg::ST_DIV)
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            mwpo_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    voice_reg <= in_ch.voice;
                    chan_reg  <= in_ch.channel;
                    pitch_reg <= in_ch.pitch_cv;
                    fm_reg    <= in_ch.fm_cv;
                    addr_reg  <= in_addr7[IDX_W-1:0];
                end
            end
            mwpo_pkg::ST_DIV_LD:
            begin
                quot_reg <= prod[mwpo_pkg::BASE_W-1:0];
                rem_reg  <= '0;
            end
            mwpo_pkg::ST_DIV:
            begin
                quot_reg <= {quot_reg[mwpo_pkg::BASE_W-2:0], rem_ge};
                rem_reg  <= rem_next;
            end
            mwpo_pkg::ST_ADD_E1: t_reg   <= mwpo_pkg::EXP_C2 + prod[28:12];
            mwpo_pkg::ST_ADD_E2: t_reg   <= mwpo_pkg::EXP_C1 + prod[28:12];
            mwpo_pkg::ST_ADD_E3: m_reg   <= mwpo_pkg::EXP_C0 + prod[28:12];
            mwpo_pkg::ST_ADD_BL: acc_reg <= {5'd0, prod[48:0]};
            mwpo_pkg::ST_ADD_BH: acc_reg <= acc_reg + {prod[21:0], 32'd0};
            mwpo_pkg::ST_SHIFT:  v_reg   <= 45'(acc_reg >> sh_amt);
            mwpo_pkg::ST_ADD_F:  f_reg   <= prod[31:0] + mwpo_pkg::F_ONE;
            mwpo_pkg::ST_ADD_L:  lo_reg  <= prod[59:28];
            mwpo_pkg::ST_ADD_H:  inc_reg <= prod[31:0] + lo_reg;
            mwpo_pkg::ST_PHASE:  p_reg   <= p_sum;
            mwpo_pkg::ST_PREP:   x_reg   <= x_w;
            mwpo_pkg::ST_ADD_S1: x2_reg  <= prod[30:15];
            mwpo_pkg::ST_ADD_S2: t_reg   <= mwpo_pkg::SIN_C2 - {4'd0, prod[27:15]};
            mwpo_pkg::ST_ADD_S3: t_reg   <= mwpo_pkg::SIN_C1 - prod[31:15];
            mwpo_pkg::ST_WAVE:   sample_reg <= wave_sat;
            default:             ;
        endcase
    end

    // Output register: hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sample_reg <= sample_reg;
            out_voice_reg  <= voice_reg;
            out_chan_reg   <= chan_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.sample      = out_sample_reg;
    assign out_ch.out_voice   = out_voice_reg;
    assign out_ch.out_channel = out_chan_reg;

endmodule

`default_nettype wire

### rtl/mwpo_checker.sv
// Port-level assertions of the oscillator and their bind to the top level.
`default_nettype none

module mwpo_checker #(
    parameter int VOICES = mwpo_pkg::DEFAULT_VOICES
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          in_func,
    input logic [2:0]                    in_voice,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [15:0]            out_sample,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [mwpo_pkg::PADDR_W-1:0]  paddr,
    input logic [mwpo_pkg::PDATA_W-1:0]  pwdata,
    input logic [mwpo_pkg::PDATA_W-1:0]  prdata,
    input logic                          pready
);

    // A tick for a live voice makes the block busy next cycle
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_func == mwpo_pkg::FUNC_TICK)
        && ({29'd0, in_voice} < 32'(VOICES)) |=> !in_ready)
        else $error("tick accepted but block still ready");

    // A new result only follows a busy cycle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without work");

    // A stalled result holds its sample
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample))
        else $error("stalled result changed");

    // Wave select reads back what was written
    a_wave_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[4:2] == mwpo_pkg::REG_WAVE_SELECT)
        |=> !(psel && !pwrite && (paddr[4:2] == mwpo_pkg::REG_WAVE_SELECT))
            || (prdata[1:0] == $past(pwdata[1:0])))
        else $error("wave select readback mismatch");

endmodule

bind multi_wave_phase_oscillator mwpo_checker #(.VOICES(VOICES)) u_mwpo_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_func    (in_ch.func),
    .in_voice   (in_ch.voice),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.sample),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
);

`default_nettype wire
